// ===== design/pwl_cal_pkg.sv =====
// shared types and constants for the piecewise-linear calibration table
package pwl_cal_pkg;

    localparam int TABLE_POINTS_DEF = 16;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SEG = 2'd1;
    localparam logic [1:0] MODE_V2D = 2'd2;
    localparam logic [1:0] MODE_D2V = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_NOSEG = 3'd3;
    localparam logic [2:0] ST_DZ    = 3'd4;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEG_RD,
        S_SEG_DIV,
        S_SEG_MUL,
        S_SEG_WR,
        S_Q_CHK,
        S_Q_SCAN,
        S_Q_RD,
        S_Q_MUL,
        S_Q_DIV,
        S_DONE
    } t_state;

    // divider request and reply
    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic signed [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic               dz;
        logic signed [31:0] quot;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return Q_MAX;
        end else if (v < -66'sd2147483648) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// ===== design/pwl_cal_div.sv =====
// serial restoring divider: (num << 16) / den, truncating, saturated
module pwl_cal_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pwl_cal_pkg::t_div_req i_req,
    output pwl_cal_pkg::t_div_rsp o_rsp
);
    import pwl_cal_pkg::*;

    // dividend magnitude up to 2^48, quotient up to 49 bits
    localparam int QW = 49;

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [QW-1:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic        r_dz, n_dz;
    logic signed [31:0] r_quot, n_quot;

    logic [32:0] num_mag, den_mag;
    logic [33:0] trial;
    logic [QW:0] qs;
    logic signed [QW+1:0] qsig;

    always_comb begin
        num_mag = i_req.num[32] ? 33'(-i_req.num) : 33'(i_req.num);
        den_mag = i_req.den[32] ? 33'(-i_req.den) : 33'(i_req.den);
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        n_dz   = r_dz;
        n_quot = r_quot;
        trial  = '0;
        qs     = '0;
        qsig   = '0;
        if (i_req.start) begin
            if (i_req.den == '0) begin
                n_done = 1'b1;
                n_dz   = 1'b1;
                n_quot = (i_req.num == '0) ? 32'sd0 : (i_req.num[32] ? Q_MIN : Q_MAX);
            end else begin
                n_busy = 1'b1;
                n_cnt  = 6'(QW);
                n_q    = {num_mag, 16'd0};
                n_rem  = '0;
                n_den  = den_mag;
                n_neg  = i_req.num[32] ^ i_req.den[32];
                n_dz   = 1'b0;
            end
        end else if (r_busy) begin
            // one quotient bit a cycle
            trial = {r_rem, r_q[QW-1]} - {1'b0, r_den};
            if (!trial[33]) begin
                n_rem = trial[32:0];
                n_q   = {r_q[QW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_q[QW-1]};
                n_q   = {r_q[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                qs     = {1'b0, n_q};
                qsig   = r_neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
                n_quot = sat32(66'(qsig));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_dz   <= n_dz;
        r_quot <= n_quot;
    end

    assign o_rsp = '{done: r_done, dz: r_dz, quot: r_quot};

endmodule

// ===== design/piecewise_linear_calibration_lut.sv =====
// top level: calibration table storage, sequencer and shared multiply
// mode 1 works segment by segment over the TABLE_POINTS-1 segments, each with a
// 49-step serial divide that a zero divisor skips; mode 2 scans the table and
// mode 3 scans it and then runs the serial divide
// busy holds through the result strobe, so a new beat can be taken from the cycle after it
// synchronous active-low reset clears fill count, valid bits and the sequencer;
// the result has no backpressure: o_valid lasts exactly one cycle
module piecewise_linear_calibration_lut #(
    parameter int TABLE_POINTS = pwl_cal_pkg::TABLE_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic signed [31:0] i_in_distance,
    input  logic signed [31:0] i_in_value,
    output logic        o_valid,
    output logic signed [31:0] o_result,
    output logic [2:0]  o_status
);
    import pwl_cal_pkg::*;

    localparam int IW = $clog2(TABLE_POINTS);
    localparam int CW = $clog2(TABLE_POINTS + 1);
    localparam int SEGS = TABLE_POINTS - 1;

    // point and segment stores, cleared by valid bits
    logic signed [31:0] r_pd [TABLE_POINTS];
    logic signed [31:0] r_pv [TABLE_POINTS];
    logic signed [31:0] r_sl [SEGS];
    logic signed [31:0] r_ic [SEGS];
    logic [TABLE_POINTS-1:0] r_pvld;
    logic [SEGS-1:0] r_svld;
    logic [CW-1:0] r_fill;

    t_state r_state, n_state;
    logic [1:0]  r_mode;
    logic signed [31:0] r_q;
    logic [IW-1:0] r_idx;
    logic        r_dzf;
    logic signed [31:0] r_a, r_b;   // scratch: segment start distance and value
    logic signed [31:0] r_s, r_k;
    logic signed [63:0] r_p;
    logic signed [31:0] r_res;
    logic [2:0]  r_st;
    logic        r_vld;
    logic        accept;

    t_div_req div_req;
    t_div_rsp div_rsp;

    pwl_cal_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    function automatic logic signed [31:0] rd(input logic signed [31:0] v, input logic ok);
        return ok ? v : 32'sd0;
    endfunction

    logic [IW-1:0] idx1;
    logic signed [31:0] pd0, pd1, pv0, pv1, sl0, ic0, key0, key1, keyl, keyf;
    logic signed [31:0] othl, othf;
    logic signed [63:0] mul_a, mul_b, mul_p;
    logic signed [47:0] flr;

    assign accept = start && !busy;

    always_comb begin
        idx1 = r_idx + IW'(1);
        pd0 = rd(r_pd[r_idx], r_pvld[r_idx]);
        pd1 = rd(r_pd[idx1], r_pvld[idx1]);
        pv0 = rd(r_pv[r_idx], r_pvld[r_idx]);
        pv1 = rd(r_pv[idx1], r_pvld[idx1]);
        sl0 = rd(r_sl[r_idx], r_svld[r_idx]);
        ic0 = rd(r_ic[r_idx], r_svld[r_idx]);
        key0 = (r_mode == MODE_V2D) ? pv0 : pd0;
        key1 = (r_mode == MODE_V2D) ? pv1 : pd1;
        keyl = (r_mode == MODE_V2D) ? rd(r_pv[IW'(SEGS)], r_pvld[SEGS])
                                    : rd(r_pd[IW'(SEGS)], r_pvld[SEGS]);
        keyf = (r_mode == MODE_V2D) ? rd(r_pv[0], r_pvld[0]) : rd(r_pd[0], r_pvld[0]);
        othl = (r_mode == MODE_V2D) ? rd(r_pd[IW'(SEGS)], r_pvld[SEGS])
                                    : rd(r_pv[IW'(SEGS)], r_pvld[SEGS]);
        othf = (r_mode == MODE_V2D) ? rd(r_pd[0], r_pvld[0]) : rd(r_pv[0], r_pvld[0]);
        // shared multiplier
        mul_a = 64'(r_s);
        mul_b = (r_state == S_SEG_MUL) ? 64'(r_b) : 64'(r_q);
        mul_p = mul_a * mul_b;
        flr = r_p[63:16];   // arithmetic shift equals floor
    end

    always_comb begin
        n_state = r_state;
        div_req = '{start: 1'b0, num: '0, den: '0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_ADD: n_state = S_DONE;
                        MODE_SEG: n_state = S_SEG_RD;
                        default:  n_state = S_Q_CHK;
                    endcase
                end
            end
            S_SEG_RD: begin
                n_state = S_SEG_DIV;
                div_req = '{start: 1'b1, num: 33'(pd1) - 33'(pd0), den: 33'(pv1) - 33'(pv0)};
            end
            S_SEG_DIV: if (div_rsp.done) n_state = S_SEG_MUL;
            S_SEG_MUL: n_state = S_SEG_WR;
            S_SEG_WR: n_state = (r_idx == IW'(SEGS - 1)) ? S_DONE : S_SEG_RD;
            S_Q_CHK: n_state = (r_q < keyl || r_q > keyf) ? S_DONE : S_Q_SCAN;
            S_Q_SCAN: begin
                if (key0 >= r_q && r_q >= key1) begin
                    n_state = S_Q_RD;
                end else if (r_idx == IW'(SEGS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_Q_RD: begin
                if (r_mode == MODE_V2D) begin
                    n_state = S_Q_MUL;
                end else begin
                    n_state = S_Q_DIV;
                    div_req = '{start: 1'b1, num: 33'(r_q) - 33'(r_k), den: 33'(r_s)};
                end
            end
            S_Q_MUL: n_state = S_DONE;
            S_Q_DIV: if (div_rsp.done) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pvld  <= '0;
            r_svld  <= '0;
            r_fill  <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= i_mode;
                        r_q    <= (i_mode == MODE_V2D) ? i_in_value : i_in_distance;
                        r_idx  <= '0;
                        r_dzf  <= 1'b0;
                        r_res  <= '0;
                        r_st   <= (i_mode == MODE_ADD && r_fill == CW'(TABLE_POINTS))
                                  ? ST_FULL : ST_OK;
                        if (i_mode == MODE_ADD && r_fill != CW'(TABLE_POINTS)) begin
                            r_pd[r_fill[IW-1:0]]   <= i_in_distance;
                            r_pv[r_fill[IW-1:0]]   <= i_in_value;
                            r_pvld[r_fill[IW-1:0]] <= 1'b1;
                            r_fill <= r_fill + CW'(1);
                        end
                    end
                end
                S_SEG_RD: begin
                    r_a <= pd0;
                    r_b <= pv0;
                end
                S_SEG_DIV: begin
                    if (div_rsp.done) begin
                        r_s <= div_rsp.quot;
                        if (div_rsp.dz) r_dzf <= 1'b1;
                    end
                end
                S_SEG_MUL: r_p <= mul_p;
                S_SEG_WR: begin
                    r_sl[r_idx]   <= r_s;
                    r_ic[r_idx]   <= sat32(66'(r_a) - 66'(flr));
                    r_svld[r_idx] <= 1'b1;
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == IW'(SEGS - 1)) r_st <= (r_dzf) ? ST_DZ : ST_OK;
                end
                S_Q_CHK: begin
                    if (r_q < keyl) begin
                        r_res <= othl;
                        r_st  <= ST_CLAMP;
                    end else if (r_q > keyf) begin
                        r_res <= othf;
                        r_st  <= ST_CLAMP;
                    end
                end
                S_Q_SCAN: begin
                    if (key0 >= r_q && r_q >= key1) begin
                        r_s <= sl0;
                        r_k <= ic0;
                    end else if (r_idx == IW'(SEGS - 1)) begin
                        r_res <= '0;
                        r_st  <= ST_NOSEG;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_Q_RD: if (r_mode == MODE_V2D) r_p <= mul_p;
                S_Q_MUL: r_res <= sat32(66'(flr) + 66'(r_k));
                S_Q_DIV: begin
                    if (div_rsp.done) begin
                        r_res <= div_rsp.quot;
                        r_st  <= div_rsp.dz ? ST_DZ : ST_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE) || r_vld;
    assign o_valid  = r_vld;
    assign o_result = r_res;
    assign o_status = r_st;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_POINTS)) else $error("fill count past table size");
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("strobe while idle");
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("done without strobe");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_DZ)) else $error("bad status code");

endmodule
